// ===== rtl/cta_pkg.sv =====
// Shared types and op codes for the CIGAR expansion block.
package cta_pkg;

	localparam int MaxChunk = 64;
	localparam int LenW     = 7;

	localparam logic [3:0] OP_M = 4'd0;
	localparam logic [3:0] OP_I = 4'd1;
	localparam logic [3:0] OP_D = 4'd2;
	localparam logic [3:0] OP_N = 4'd3;
	localparam logic [3:0] OP_S = 4'd4;
	localparam logic [3:0] OP_H = 4'd5;
	localparam logic [3:0] OP_P = 4'd6;
	localparam logic [3:0] OP_EQ = 4'd7;
	localparam logic [3:0] OP_X = 4'd8;

	localparam logic [1:0] ERR_OK   = 2'd0;
	localparam logic [1:0] ERR_HARD = 2'd1;
	localparam logic [1:0] ERR_OP   = 2'd2;

	typedef struct packed {
		logic        record_first;
		logic        strand_rev;
		logic [30:0] align_start;
		logic [30:0] align_end;
		logic [3:0]  op_code;
		logic [27:0] op_total_len;
		logic [27:0] chunk_offset;
		logic [6:0]  chunk_len;
	} item_t;

	typedef struct packed {
		logic [30:0]        read_index;
		logic               aligned_valid;
		logic signed [31:0] aligned_ref;
		logic               insert_valid;
		logic signed [31:0] insert_anchor;
		logic [27:0]        insert_offset;
		logic [1:0]         error_code;
		logic               run_last;
	} result_t;

endpackage

// ===== rtl/cta_if.sv =====
// Valid/ready channel interfaces for input items and results.
interface cta_item_if;
	import cta_pkg::*;
	logic  valid;
	logic  ready;
	item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface cta_result_if;
	import cta_pkg::*;
	logic    valid;
	logic    ready;
	result_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/cigar_to_aligned_positions.sv =====
// CIGAR chunk expansion into per-base aligned and inserted positions.
// The input transaction is registered into state and position registers, then the first
// result into the output register; an output stall can hold it between the two.
// Throughput: one result per base after accept while the output is not stalled; an error
// chunk gives one result, a deletion, skip or empty chunk none; input is ready only when idle.
// Reset: arst_n clears counters, state, output valid and enable_insertions.
module cigar_to_aligned_positions (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic              cfg_wr_data,
	cta_item_if.sink          item,
	cta_result_if.source      result
);
	import cta_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_ERR  = 2'd2;

	logic [1:0]  state_q;
	logic        ena_ins_q;
	logic [30:0] read_q;
	logic [30:0] ref_q;
	logic [LenW-1:0] cnt_q;
	logic [27:0] j_q;
	logic [27:0] total_q;
	logic [31:0] mir_sum_q;
	logic [3:0]  op_q;
	logic        rev_q;
	logic [1:0]  err_q;
	logic        out_valid_q;
	result_t     out_q;

	logic        accept;
	logic        out_free;
	logic        emit;
	logic [30:0] rd_base;
	logic [30:0] rf_base;
	logic [LenW-1:0] sat_len;
	logic [31:0] ref_ext;
	logic [31:0] mirror;
	logic        is_align;
	logic        is_ins;
	result_t     res_d;

	assign item.ready   = (state_q == ST_IDLE);
	assign accept       = item.valid && item.ready;
	assign out_free     = !out_valid_q || result.ready;
	assign emit         = out_free && (state_q == ST_RUN || state_q == ST_ERR);
	assign result.valid = out_valid_q;
	assign result.data  = out_q;

	assign rd_base = item.data.record_first ? '0 : read_q;
	assign rf_base = item.data.record_first ? item.data.align_start : ref_q;
	assign sat_len = (item.data.chunk_len > LenW'(MaxChunk)) ? LenW'(MaxChunk)
		: item.data.chunk_len;

	assign ref_ext  = {1'b0, ref_q};
	assign mirror   = mir_sum_q - ref_ext;
	assign is_align = (op_q == OP_M) || (op_q == OP_EQ) || (op_q == OP_X);
	assign is_ins   = (op_q == OP_I) && ena_ins_q;

	always_comb begin
		res_d = '0;
		res_d.read_index = read_q;
		if (state_q == ST_ERR) begin
			res_d.error_code = err_q;
			res_d.run_last   = 1'b1;
		end else begin
			res_d.run_last = (cnt_q == LenW'(1));
			if (is_align) begin
				res_d.aligned_valid = 1'b1;
				res_d.aligned_ref   = rev_q ? mirror : ref_ext;
			end else if (is_ins) begin
				res_d.insert_valid  = 1'b1;
				res_d.insert_anchor = rev_q ? mirror : ref_ext - 32'd1;
				res_d.insert_offset = rev_q ? total_q - j_q : j_q + 28'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ena_ins_q <= 1'b0;
		end else if (cfg_wr_en) begin
			ena_ins_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			read_q      <= '0;
			ref_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						read_q <= rd_base;
						ref_q  <= rf_base;
						case (item.data.op_code) inside
							OP_M, OP_I, OP_S, OP_EQ, OP_X: begin
								cnt_q <= sat_len;
								if (sat_len != '0) begin
									state_q <= ST_RUN;
								end
							end
							OP_D, OP_N: begin
								ref_q <= rf_base + 31'(sat_len);
							end
							default: begin
								state_q <= ST_ERR;
							end
						endcase
					end
				end
				ST_RUN: begin
					if (emit) begin
						read_q <= read_q + 31'd1;
						if (is_align) begin
							ref_q <= ref_q + 31'd1;
						end
						cnt_q <= cnt_q - LenW'(1);
						if (cnt_q == LenW'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_ERR: begin
					if (emit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= item.data.op_code;
			rev_q     <= item.data.strand_rev;
			j_q       <= item.data.chunk_offset;
			total_q   <= item.data.op_total_len;
			mir_sum_q <= {1'b0, item.data.align_start} + {1'b0, item.data.align_end}
				- 32'd1;
			err_q     <= (item.data.op_code == OP_H) ? ERR_HARD : ERR_OP;
		end else if (emit && state_q == ST_RUN) begin
			j_q <= j_q + 28'd1;
		end
		if (emit) begin
			out_q <= res_d;
		end
	end

	a_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> cnt_q != '0)
		else $error("running with empty base count");

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		emit && state_q == ST_RUN && cnt_q == LenW'(1) |=> state_q == ST_IDLE)
		else $error("last base did not return to idle");

	a_kind_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.aligned_valid && out_q.insert_valid))
		else $error("result both aligned and inserted");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.error_code != ERR_OK |-> out_q.run_last)
		else $error("error result not marked last");

endmodule
